@@ design/least_laxity_scheduler_core_defines.svh @@
// Assertion macros shared by the scheduler checker.
`ifndef LEAST_LAXITY_SCHEDULER_CORE_DEFINES_SVH
`define LEAST_LAXITY_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define LLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed: same-cycle rule");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define LLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed: next-cycle rule");

`endif

@@ design/lls_pkg.sv @@
// Package with shared constants and types of the least-laxity scheduler.
package lls_pkg;

    // Default sizing of the task table and of the time fields.
    localparam int DEF_MAX_TASKS  = 8;
    localparam int DEF_TIME_WIDTH = 16;

    // Fixed widths of the request and response fields.
    localparam int FIELD_W = 16;
    localparam int TICK_W  = 32;
    localparam int EXT_W   = 32;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int CNT_REG_W  = 4;

    // Word index of the task count register.
    localparam logic REG_TASK_COUNT = 1'b0;

    // Value of the task count register after reset.
    localparam logic [CNT_REG_W-1:0] TASK_COUNT_RESET = 4'd1;

    // Request modes.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef logic [2:0]              task_id_t;
    typedef logic [FIELD_W-1:0]      field_t;
    typedef logic [TICK_W-1:0]       tick_t;
    typedef logic [APB_ADDR_W-1:0]   apb_addr_t;
    typedef logic [APB_DATA_W-1:0]   apb_data_t;

endpackage

@@ design/lls_lax_unit.sv @@
// Shared laxity subtractor and comparator used once per scanned task entry.
module lls_lax_unit #(
    parameter int TIME_WIDTH = lls_pkg::DEF_TIME_WIDTH
) (
    input  logic [TIME_WIDTH-1:0]      ttd,
    input  logic [TIME_WIDTH-1:0]      work,
    input  logic                       rdy,
    input  logic                       have_best,
    input  logic signed [TIME_WIDTH:0] best,
    output logic signed [TIME_WIDTH:0] lax,
    output logic                       take
);
    import lls_pkg::*;

    // Laxity is ticks to deadline minus work left, one bit wider and signed.
    assign lax = $signed({1'b0, ttd}) - $signed({1'b0, work});

    // A ready entry wins on the first find or on a tie, so higher indexes win ties.
    assign take = rdy && (!have_best || (lax <= best));

endmodule

@@ design/least_laxity_scheduler_core.sv @@
// Top level of the least-laxity-first tick scheduler with its sequencer and task state.
//
//  Channel    | Signals                                         | Transfer
//  -----------+-------------------------------------------------+-------------------------
//  request    | mode task_index task_period task_exec           | req_valid & req_ready
//  response   | tick_number busy_res running_task missed        | rsp_valid & rsp_ready
//             | missed_task halted                              |
//  config     | psel penable pwrite paddr pwdata prdata pready  | psel & penable & pwrite
//
// A load request is accepted in IDLE and the sequencer stays there. A tick request goes
// IDLE (accept), SCAN (each active entry in turn through the shared laxity unit), APPLY
// (charge the chosen task), RESULT (post the response). A halted tick goes IDLE to RESULT.
// Reset clears control and task state at once, with no sweep, but not tables or payload.
// A response waits in its own state while the previous one is not yet taken.
module least_laxity_scheduler_core #(
    parameter int MAX_TASKS  = lls_pkg::DEF_MAX_TASKS,
    parameter int TIME_WIDTH = lls_pkg::DEF_TIME_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    // Request channel
    input  logic                req_valid,
    output logic                req_ready,
    input  logic                mode,
    input  lls_pkg::task_id_t   task_index,
    input  lls_pkg::field_t     task_period,
    input  lls_pkg::field_t     task_exec,
    // Response channel
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output lls_pkg::tick_t      tick_number,
    output logic                busy_res,
    output lls_pkg::task_id_t   running_task,
    output logic                missed,
    output lls_pkg::task_id_t   missed_task,
    output logic                halted,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  lls_pkg::apb_addr_t  paddr,
    input  lls_pkg::apb_data_t  pwdata,
    output lls_pkg::apb_data_t  prdata,
    output logic                pready
);
    import lls_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int LAX_W = TIME_WIDTH + 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_APPLY  = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    // Sequencer and task state
    logic [1:0]                state_reg, state_next;
    logic [IDX_W-1:0]          cnt_reg, cnt_next;
    logic [IDX_W-1:0]          best_idx_reg, best_idx_next;
    logic signed [LAX_W-1:0]   best_lax_reg, best_lax_next;
    logic                      found_reg, found_next;
    logic                      miss_reg, miss_next;
    logic [IDX_W-1:0]          miss_idx_reg, miss_idx_next;
    logic [IDX_W-1:0]          last_choice_reg, last_choice_next;
    logic [TICK_W-1:0]         time_reg, time_next;
    logic                      stopped_reg, stopped_next;
    logic [TICK_W-1:0]         res_tick_reg, res_tick_next;
    logic                      res_busy_reg, res_busy_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    logic [CNT_REG_W-1:0]      task_count_reg, task_count_next;

    logic [TIME_WIDTH-1:0]     work_reg [MAX_TASKS];
    logic [TIME_WIDTH-1:0]     work_next [MAX_TASKS];
    logic [TIME_WIDTH-1:0]     ttd_reg [MAX_TASKS];
    logic [TIME_WIDTH-1:0]     ttd_next [MAX_TASKS];
    logic [MAX_TASKS-1:0]      rdy_reg, rdy_next;

    // Task tables, undefined until loaded
    logic [TIME_WIDTH-1:0]     period_tab [MAX_TASKS];
    logic [TIME_WIDTH-1:0]     exec_tab [MAX_TASKS];

    // Response payload registers
    logic [TICK_W-1:0]         out_tick_reg;
    logic                      out_busy_reg;
    task_id_t                  out_run_reg;
    logic                      out_miss_reg;
    task_id_t                  out_miss_idx_reg;
    logic                      out_halt_reg;
    logic                      rsp_load;

    // Datapath signals for the entry under the sequencer
    logic                      req_fire;
    logic                      tbl_we;
    logic [IDX_W-1:0]          tbl_widx;
    logic [EXT_W-1:0]          period_ext;
    logic [EXT_W-1:0]          exec_ext;
    logic [IDX_W-1:0]          rd_idx;
    logic [TIME_WIDTH-1:0]     rd_ttd;
    logic [TIME_WIDTH-1:0]     rd_work;
    logic                      rd_rdy;
    logic [TIME_WIDTH-1:0]     rd_per;
    logic [TIME_WIDTH-1:0]     rd_exec;
    logic                      release_hit;
    logic [TIME_WIDTH-1:0]     ttd_new;
    logic [TIME_WIDTH-1:0]     work_new;
    logic                      rdy_new;
    logic signed [LAX_W-1:0]   lax;
    logic                      take;
    logic [CNT_REG_W-1:0]      n_act;
    logic [CNT_REG_W-1:0]      n_last_full;
    logic [IDX_W-1:0]          n_last;
    logic                      cfg_we;

    // Configuration register access
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_TASK_COUNT);
    assign prdata = (paddr[2] == REG_TASK_COUNT) ? APB_DATA_W'(task_count_reg) : '0;

    // Active entry count, clamped to the table size, with zero read as one
    always_comb
    begin
        if (task_count_reg == '0)
        begin
            n_act = CNT_REG_W'(1);
        end
        else if (task_count_reg > CNT_REG_W'(MAX_TASKS))
        begin
            n_act = CNT_REG_W'(MAX_TASKS);
        end
        else
        begin
            n_act = task_count_reg;
        end
    end
    assign n_last_full = n_act - CNT_REG_W'(1);
    assign n_last      = n_last_full[IDX_W-1:0];

    // Request handshake and table write decode
    assign req_ready  = (state_reg == ST_IDLE);
    assign req_fire   = req_valid && req_ready;
    assign tbl_we     = req_fire && (mode == MODE_LOAD)
                        && ({29'd0, task_index} < 32'(MAX_TASKS));
    assign tbl_widx   = task_index[IDX_W-1:0];
    assign period_ext = EXT_W'(task_period);
    assign exec_ext   = EXT_W'(task_exec);

    // One read port into the task state: the scan counter, or the chosen task
    assign rd_idx  = (state_reg == ST_APPLY) ? best_idx_reg : cnt_reg;
    assign rd_ttd  = ttd_reg[rd_idx];
    assign rd_work = work_reg[rd_idx];
    assign rd_rdy  = rdy_reg[rd_idx];
    assign rd_per  = period_tab[rd_idx];
    assign rd_exec = exec_tab[rd_idx];

    // Release of the scanned entry when its countdown has run out
    assign release_hit = (rd_ttd == '0);
    assign ttd_new  = release_hit ? ((rd_per == '0) ? TIME_WIDTH'(1) : rd_per) : rd_ttd;
    assign work_new = release_hit ? rd_exec : rd_work;
    assign rdy_new  = release_hit ? (rd_exec != '0) : rd_rdy;

    lls_lax_unit #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_lax (
        .ttd       (ttd_new),
        .work      (work_new),
        .rdy       (rdy_new),
        .have_best (found_reg),
        .best      (best_lax_reg),
        .lax       (lax),
        .take      (take)
    );

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        best_idx_next    = best_idx_reg;
        best_lax_next    = best_lax_reg;
        found_next       = found_reg;
        miss_next        = miss_reg;
        miss_idx_next    = miss_idx_reg;
        last_choice_next = last_choice_reg;
        time_next        = time_reg;
        stopped_next     = stopped_reg;
        res_tick_next    = res_tick_reg;
        res_busy_next    = res_busy_reg;
        task_count_next  = cfg_we ? pwdata[CNT_REG_W-1:0] : task_count_reg;
        work_next        = work_reg;
        ttd_next         = ttd_reg;
        rdy_next         = rdy_reg;
        rsp_load         = 1'b0;

        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (mode == MODE_LOAD)
                    begin
                        // Restart the schedule at time zero.
                        for (int i = 0; i < MAX_TASKS; i++)
                        begin
                            work_next[i] = '0;
                            ttd_next[i]  = '0;
                        end
                        rdy_next         = '0;
                        last_choice_next = '0;
                        time_next        = '0;
                        stopped_next     = 1'b0;
                    end
                    else if (stopped_reg)
                    begin
                        // Halted: report the frozen time, no busy and no miss, and leave task state alone.
                        res_tick_next = time_reg;
                        res_busy_next = 1'b0;
                        miss_next     = 1'b0;
                        miss_idx_next = '0;
                        state_next    = ST_RESULT;
                    end
                    else
                    begin
                        cnt_next      = '0;
                        found_next    = 1'b0;
                        miss_next     = 1'b0;
                        miss_idx_next = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Release, miss check and laxity compare for one entry.
                if (release_hit && (rd_work != '0))
                begin
                    miss_next     = 1'b1;
                    miss_idx_next = cnt_reg;
                end
                work_next[cnt_reg] = work_new;
                rdy_next[cnt_reg]  = rdy_new;
                ttd_next[cnt_reg]  = ttd_new - TIME_WIDTH'(1);
                if (take)
                begin
                    found_next    = 1'b1;
                    best_lax_next = lax;
                    best_idx_next = cnt_reg;
                end
                if (cnt_reg == n_last)
                begin
                    state_next = ST_APPLY;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end

            ST_APPLY:
            begin
                // Run the chosen task, if any, for one unit and advance time, saturating at its maximum.
                if (found_reg)
                begin
                    work_next[best_idx_reg] = rd_work - TIME_WIDTH'(1);
                    rdy_next[best_idx_reg]  = (rd_work != TIME_WIDTH'(1));
                    last_choice_next        = best_idx_reg;
                end
                res_busy_next = found_reg;
                res_tick_next = time_reg;
                if (time_reg != '1)
                begin
                    time_next = time_reg + TICK_W'(1);
                end
                stopped_next = miss_reg;
                state_next   = ST_RESULT;
            end

            ST_RESULT:
            begin
                // Post the response once the output register is free.
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and task state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            best_idx_reg    <= '0;
            best_lax_reg    <= '0;
            found_reg       <= 1'b0;
            miss_reg        <= 1'b0;
            miss_idx_reg    <= '0;
            last_choice_reg <= '0;
            time_reg        <= '0;
            stopped_reg     <= 1'b0;
            res_tick_reg    <= '0;
            res_busy_reg    <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            task_count_reg  <= TASK_COUNT_RESET;
            rdy_reg         <= '0;
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                work_reg[i] <= '0;
                ttd_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            best_idx_reg    <= best_idx_next;
            best_lax_reg    <= best_lax_next;
            found_reg       <= found_next;
            miss_reg        <= miss_next;
            miss_idx_reg    <= miss_idx_next;
            last_choice_reg <= last_choice_next;
            time_reg        <= time_next;
            stopped_reg     <= stopped_next;
            res_tick_reg    <= res_tick_next;
            res_busy_reg    <= res_busy_next;
            rsp_valid_reg   <= rsp_valid_next;
            task_count_reg  <= task_count_next;
            rdy_reg         <= rdy_next;
            work_reg        <= work_next;
            ttd_reg         <= ttd_next;
        end
    end

    // Task tables, written by load requests
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            period_tab[tbl_widx] <= period_ext[TIME_WIDTH-1:0];
            exec_tab[tbl_widx]   <= exec_ext[TIME_WIDTH-1:0];
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            out_tick_reg     <= res_tick_reg;
            out_busy_reg     <= res_busy_reg;
            out_run_reg      <= 3'(last_choice_reg);
            out_miss_reg     <= miss_reg;
            out_miss_idx_reg <= 3'(miss_idx_reg);
            out_halt_reg     <= stopped_reg;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign tick_number  = out_tick_reg;
    assign busy_res     = out_busy_reg;
    assign running_task = out_run_reg;
    assign missed       = out_miss_reg;
    assign missed_task  = out_miss_idx_reg;
    assign halted       = out_halt_reg;

endmodule

@@ design/lls_checker.sv @@
// Port-level checker for the least-laxity scheduler, bound to its top level.
`include "least_laxity_scheduler_core_defines.svh"

module lls_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  logic                mode,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  lls_pkg::tick_t      tick_number,
    input  logic                missed,
    input  lls_pkg::task_id_t   missed_task,
    input  logic                halted
);
    import lls_pkg::*;

    // A stalled response keeps its valid and its tick number.
    `LLS_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(tick_number))

    // A deadline miss always halts scheduling in the same response.
    `LLS_ASSERT_NOW(a_miss_halts, clk, rst_n, rsp_valid && missed, halted)

    // With no miss reported the miss index reads zero.
    `LLS_ASSERT_NOW(a_miss_idx_zero, clk, rst_n, rsp_valid && !missed, missed_task == '0)

    // A load request leaves the block ready again in the next cycle.
    `LLS_ASSERT_NEXT(a_load_one_cycle, clk, rst_n, req_valid && req_ready && (mode == MODE_LOAD), req_ready)

endmodule

bind least_laxity_scheduler_core lls_checker u_lls_checker (.*);
